>>> src/ncc_template_match_search_assert.svh
// assertion macros for the template match search block
`ifndef NCC_TEMPLATE_MATCH_SEARCH_ASSERT_SVH
`define NCC_TEMPLATE_MATCH_SEARCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
// consequent checked in the same cycle as the antecedent
`define NCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ncc check failed");
// consequent checked in the cycle after the antecedent
`define NCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncc check failed");
`else
`define NCC_ASSERT_SAME(label, ante, cons)
`define NCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/ncc_tms_pkg.sv
// shared types and constants of the template match search block
package ncc_tms_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int CFG_TW_W  = 6;
    localparam int CFG_TH_W  = 6;
    localparam int CFG_IW_W  = 9;
    localparam int CFG_IH_W  = 9;
    localparam int CFG_THR_W = 21;

    localparam logic [CFG_TW_W-1:0]  TW_RESET  = 6'd8;
    localparam logic [CFG_TH_W-1:0]  TH_RESET  = 6'd8;
    localparam logic [CFG_IW_W-1:0]  IW_RESET  = 9'd64;
    localparam logic [CFG_IH_W-1:0]  IH_RESET  = 9'd64;
    localparam logic [CFG_THR_W-1:0] THR_RESET = 21'd655360;

    localparam logic [2:0] REG_TEMPLATE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_TEMPLATE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_MATCH_THRESHOLD = 3'd4;

    localparam logic FUNC_TEMPLATE = 1'b0;
    localparam logic FUNC_IMAGE    = 1'b1;

    localparam int SCORE_W = 18;
    localparam int POS_W   = 8;
    // threshold is unsigned Q5.16; score and threshold are compared at 32 fraction bits
    localparam int THR_FRAC_BITS = 16;

    typedef struct packed {
        logic       func;
        logic [7:0] pixel;
        logic       last;
    } in_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] best_score;
        logic [POS_W-1:0]          best_row;
        logic [POS_W-1:0]          best_col;
        logic                      found;
    } out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_TPASS,
        ST_DT1,
        ST_DT2,
        ST_ND,
        ST_WIN_INIT,
        ST_WIN,
        ST_A1,
        ST_A2,
        ST_DS1,
        ST_DS2,
        ST_K,
        ST_AA,
        ST_L,
        ST_ROOT,
        ST_NEXT,
        ST_DONE
    } state_t;

endpackage

>>> src/ncc_tms_ram.sv
// generic single write port memory with registered read
module ncc_tms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ncc_tms_mul.sv
// shared shift-add multiplier, one multiplier bit per cycle
module ncc_tms_mul #(
    parameter int MC_W = 98,
    parameter int MP_W = 38
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [MC_W-1:0]         mcand,
    input  logic [MP_W-1:0]         mplier,
    output logic [MC_W-1:0]         product,
    output ncc_tms_pkg::unit_stat_t stat
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [MC_W-1:0] acc_reg, acc_next;
    logic [MC_W-1:0] mc_reg, mc_next;
    logic [MP_W-1:0] mp_reg, mp_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        if (start)
        begin
            busy_next = 1'b1;
            acc_next  = '0;
            mc_next   = mcand;
            mp_next   = mplier;
        end
        else if (busy_reg)
        begin
            if (mp_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (mp_reg[0])
                begin
                    acc_next = acc_reg + mc_reg;
                end
                mc_next = mc_reg << 1;
                mp_next = mp_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> src/ncc_tms_root.sv
// score search: largest q with q*q*k <= l * 2^(2*frac), msb first
module ncc_tms_root #(
    parameter int KW   = 98,
    parameter int FRAC = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [KW-1:0]           k,
    input  logic [KW-1:0]           l,
    output logic [FRAC:0]           q,
    output ncc_tms_pkg::unit_stat_t stat
);

    localparam int RW = KW + 2 * FRAC + 4;
    localparam int BW = $clog2(FRAC + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          phase_reg, phase_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [RW-1:0] kq2_reg, kq2_next;
    logic [RW-1:0] kqs_reg, kqs_next;
    logic [RW-1:0] ks_reg, ks_next;
    logic [RW-1:0] lsh_reg, lsh_next;
    logic [RW-1:0] t_reg, t_next;
    logic [FRAC:0] q_reg, q_next;
    logic [RW-1:0] cand;

    // kq2 = k*q*q, kqs = k*q << (bit+1), ks = k << (2*bit)
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        kq2_next   = kq2_reg;
        kqs_next   = kqs_reg;
        ks_next    = ks_reg;
        lsh_next   = lsh_reg;
        t_next     = t_reg;
        q_next     = q_reg;
        cand       = t_reg + ks_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            bit_next   = BW'(FRAC);
            kq2_next   = '0;
            kqs_next   = '0;
            ks_next    = RW'(k) << (2 * FRAC);
            lsh_next   = RW'(l) << (2 * FRAC);
            q_next     = '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                t_next     = kq2_reg + kqs_reg;
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                if (cand <= lsh_reg)
                begin
                    kq2_next = cand;
                    kqs_next = (kqs_reg >> 1) + ks_reg;
                    q_next   = q_reg | ((FRAC + 1)'(1) << bit_reg);
                end
                else
                begin
                    kqs_next = kqs_reg >> 1;
                end
                ks_next = ks_reg >> 2;
                if (bit_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kq2_reg <= kq2_next;
        kqs_reg <= kqs_next;
        ks_reg  <= ks_next;
        lsh_reg <= lsh_next;
        t_reg   <= t_next;
        q_reg   <= q_next;
    end

    assign q         = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> src/ncc_template_match_search.sv
// normalized cross-correlation template search, top level
//
//   channel   direction  handshake              carries
//   in_data   in         in_valid / in_ready    func, pixel, last
//   out_data  out        out_valid / out_ready  best_score, best_row, best_col, found
//   apb       in         psel / penable         five configuration registers
//
// an image request with last set starts the search; template requests ignore last
// search: a template pass and three products, then per window a pixel pass,
//   up to seven shift-add products on the shared multiplier and a bit-by-bit
//   search in the score unit
// in_ready is low from the last pixel until the result is in the output register
// the result waits in the output register; loads are taken meanwhile
`include "ncc_template_match_search_assert.svh"
module ncc_template_match_search #(
    parameter int MAX_TEMPLATE_W  = 32,
    parameter int MAX_TEMPLATE_H  = 32,
    parameter int MAX_IMAGE_W     = 256,
    parameter int MAX_IMAGE_H     = 256,
    parameter int SCORE_FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ncc_tms_pkg::PADDR_W-1:0]    paddr,
    input  logic [ncc_tms_pkg::PDATA_W-1:0]    pwdata,
    output logic [ncc_tms_pkg::PDATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ncc_tms_pkg::in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ncc_tms_pkg::out_t                  out_data
);

    localparam int TDEPTH = MAX_TEMPLATE_W * MAX_TEMPLATE_H;
    localparam int IDEPTH = MAX_IMAGE_W * MAX_IMAGE_H;
    localparam int TA_W   = $clog2(TDEPTH);
    localparam int IA_W   = $clog2(IDEPTH);
    localparam int TC_W   = $clog2(TDEPTH + 1);
    localparam int IC_W   = $clog2(IDEPTH + 1);
    localparam int NW     = TC_W;
    localparam int SW     = NW + 8;
    localparam int QW     = NW + 16;
    localparam int DW     = 2 * NW + 16;
    localparam int MUL_W  = 2 * DW + NW;
    localparam int TW_W   = $clog2(MAX_TEMPLATE_W + 1);
    localparam int TH_W   = $clog2(MAX_TEMPLATE_H + 1);
    localparam int IW_W   = $clog2(MAX_IMAGE_W + 1);
    localparam int IH_W   = $clog2(MAX_IMAGE_H + 1);
    localparam int Q_W    = SCORE_FRAC_BITS + 1;
    localparam int CMP_W  = Q_W + ncc_tms_pkg::CFG_THR_W + ncc_tms_pkg::THR_FRAC_BITS
                            + SCORE_FRAC_BITS;

    // configuration registers
    logic [ncc_tms_pkg::CFG_TW_W-1:0]  tw_cfg_reg;
    logic [ncc_tms_pkg::CFG_TH_W-1:0]  th_cfg_reg;
    logic [ncc_tms_pkg::CFG_IW_W-1:0]  iw_cfg_reg;
    logic [ncc_tms_pkg::CFG_IH_W-1:0]  ih_cfg_reg;
    logic [ncc_tms_pkg::CFG_THR_W-1:0] thr_cfg_reg;
    logic                              cfg_we;

    ncc_tms_pkg::state_t state_reg, state_next;

    logic [TC_W-1:0] tload_reg, tload_next;
    logic [IC_W-1:0] iload_reg, iload_next;

    logic [TW_W-1:0]  tw_c, tw_reg, tw_next;
    logic [TH_W-1:0]  th_c, th_reg, th_next;
    logic [IW_W-1:0]  iw_c, iw_reg, iw_next;
    logic [IH_W-1:0]  ih_c, ih_reg, ih_next;
    logic [NW-1:0]    n_c, n_reg, n_next;
    logic [IH_W-1:0]  r_last_reg, r_last_next, r_reg, r_next;
    logic [IW_W-1:0]  c_last_reg, c_last_next, c_reg, c_next;
    logic [TH_W-1:0]  i_reg, i_next;
    logic [TW_W-1:0]  j_reg, j_next;
    logic [IA_W-1:0]  row_base_reg, row_base_next;
    logic [IA_W-1:0]  line_base_reg, line_base_next;
    logic [TA_W-1:0]  tbase_reg, tbase_next;
    logic             issue_done_reg, issue_done_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             issued_reg, issued_next;

    logic [SW-1:0]    t1_reg, t1_next, s1_reg, s1_next;
    logic [QW-1:0]    t2_reg, t2_next, s2_reg, s2_next, sxy_reg, sxy_next;
    logic [MUL_W-1:0] tmp_reg, tmp_next, k_reg, k_next, l_reg, l_next;
    logic [DW-1:0]    dt_reg, dt_next, a_reg, a_next, ds_reg, ds_next;
    logic [DW+NW-1:0] nd_reg, nd_next;
    logic [Q_W-1:0]   best_reg, best_next;
    logic [IH_W-1:0]  best_r_reg, best_r_next;
    logic [IW_W-1:0]  best_c_reg, best_c_next;

    logic              out_valid_reg, out_valid_next;
    ncc_tms_pkg::out_t out_reg, out_next;

    logic             in_acc;
    logic             tram_we, iram_we;
    logic [TA_W-1:0]  tram_raddr;
    logic [IA_W-1:0]  iram_raddr;
    logic [7:0]       tram_rdata, iram_rdata;

    logic             mul_start;
    logic [MUL_W-1:0] mul_mcand, mul_product;
    logic [DW-1:0]    mul_mplier;
    ncc_tms_pkg::unit_stat_t mul_stat;
    logic             root_start;
    logic [Q_W-1:0]   root_q;
    ncc_tms_pkg::unit_stat_t root_stat;
    logic [CMP_W-1:0] score_cmp, thr_cmp;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_cfg_reg  <= ncc_tms_pkg::TW_RESET;
            th_cfg_reg  <= ncc_tms_pkg::TH_RESET;
            iw_cfg_reg  <= ncc_tms_pkg::IW_RESET;
            ih_cfg_reg  <= ncc_tms_pkg::IH_RESET;
            thr_cfg_reg <= ncc_tms_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                ncc_tms_pkg::REG_TEMPLATE_WIDTH:
                begin
                    tw_cfg_reg <= pwdata[ncc_tms_pkg::CFG_TW_W-1:0];
                end
                ncc_tms_pkg::REG_TEMPLATE_HEIGHT:
                begin
                    th_cfg_reg <= pwdata[ncc_tms_pkg::CFG_TH_W-1:0];
                end
                ncc_tms_pkg::REG_IMAGE_WIDTH:
                begin
                    iw_cfg_reg <= pwdata[ncc_tms_pkg::CFG_IW_W-1:0];
                end
                ncc_tms_pkg::REG_IMAGE_HEIGHT:
                begin
                    ih_cfg_reg <= pwdata[ncc_tms_pkg::CFG_IH_W-1:0];
                end
                ncc_tms_pkg::REG_MATCH_THRESHOLD:
                begin
                    thr_cfg_reg <= pwdata[ncc_tms_pkg::CFG_THR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            ncc_tms_pkg::REG_TEMPLATE_WIDTH:  prdata = ncc_tms_pkg::PDATA_W'(tw_cfg_reg);
            ncc_tms_pkg::REG_TEMPLATE_HEIGHT: prdata = ncc_tms_pkg::PDATA_W'(th_cfg_reg);
            ncc_tms_pkg::REG_IMAGE_WIDTH:     prdata = ncc_tms_pkg::PDATA_W'(iw_cfg_reg);
            ncc_tms_pkg::REG_IMAGE_HEIGHT:    prdata = ncc_tms_pkg::PDATA_W'(ih_cfg_reg);
            ncc_tms_pkg::REG_MATCH_THRESHOLD: prdata = ncc_tms_pkg::PDATA_W'(thr_cfg_reg);
            default:                          prdata = '0;
        endcase
    end

    // clamp sizes to 1..max
    always_comb
    begin
        if (tw_cfg_reg == '0)
            tw_c = TW_W'(1);
        else if (32'(tw_cfg_reg) > 32'(MAX_TEMPLATE_W))
            tw_c = TW_W'(MAX_TEMPLATE_W);
        else
            tw_c = TW_W'(tw_cfg_reg);
        if (th_cfg_reg == '0)
            th_c = TH_W'(1);
        else if (32'(th_cfg_reg) > 32'(MAX_TEMPLATE_H))
            th_c = TH_W'(MAX_TEMPLATE_H);
        else
            th_c = TH_W'(th_cfg_reg);
        if (iw_cfg_reg == '0)
            iw_c = IW_W'(1);
        else if (32'(iw_cfg_reg) > 32'(MAX_IMAGE_W))
            iw_c = IW_W'(MAX_IMAGE_W);
        else
            iw_c = IW_W'(iw_cfg_reg);
        if (ih_cfg_reg == '0)
            ih_c = IH_W'(1);
        else if (32'(ih_cfg_reg) > 32'(MAX_IMAGE_H))
            ih_c = IH_W'(MAX_IMAGE_H);
        else
            ih_c = IH_W'(ih_cfg_reg);
        n_c = NW'(NW'(tw_c) * NW'(th_c));
    end

    // pixel stores
    assign in_ready = (state_reg == ncc_tms_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign tram_we  = in_acc && (in_data.func == ncc_tms_pkg::FUNC_TEMPLATE)
                      && (tload_reg < TC_W'(TDEPTH));
    assign iram_we  = in_acc && (in_data.func == ncc_tms_pkg::FUNC_IMAGE)
                      && (iload_reg < IC_W'(IDEPTH));
    assign tram_raddr = tbase_reg + TA_W'(j_reg);
    assign iram_raddr = line_base_reg + IA_W'(j_reg);

    ncc_tms_ram #(
        .WIDTH(8),
        .DEPTH(TDEPTH)
    ) u_tram (
        .clk  (clk),
        .we   (tram_we),
        .waddr(tload_reg[TA_W-1:0]),
        .wdata(in_data.pixel),
        .raddr(tram_raddr),
        .rdata(tram_rdata)
    );

    ncc_tms_ram #(
        .WIDTH(8),
        .DEPTH(IDEPTH)
    ) u_iram (
        .clk  (clk),
        .we   (iram_we),
        .waddr(iload_reg[IA_W-1:0]),
        .wdata(in_data.pixel),
        .raddr(iram_raddr),
        .rdata(iram_rdata)
    );

    ncc_tms_mul #(
        .MC_W(MUL_W),
        .MP_W(DW)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .product(mul_product),
        .stat   (mul_stat)
    );

    ncc_tms_root #(
        .KW  (MUL_W),
        .FRAC(SCORE_FRAC_BITS)
    ) u_root (
        .clk  (clk),
        .rst_n(rst_n),
        .start(root_start),
        .k    (k_reg),
        .l    (l_reg),
        .q    (root_q),
        .stat (root_stat)
    );

    assign score_cmp = CMP_W'(best_reg) << ncc_tms_pkg::THR_FRAC_BITS;
    assign thr_cmp   = CMP_W'(thr_cfg_reg) << SCORE_FRAC_BITS;

    always_comb
    begin
        state_next      = state_reg;
        tload_next      = tload_reg;
        iload_next      = iload_reg;
        tw_next         = tw_reg;
        th_next         = th_reg;
        iw_next         = iw_reg;
        ih_next         = ih_reg;
        n_next          = n_reg;
        r_last_next     = r_last_reg;
        c_last_next     = c_last_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        row_base_next   = row_base_reg;
        line_base_next  = line_base_reg;
        tbase_next      = tbase_reg;
        issue_done_next = issue_done_reg;
        rd_valid_next   = 1'b0;
        issued_next     = issued_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        s1_next         = s1_reg;
        s2_next         = s2_reg;
        sxy_next        = sxy_reg;
        tmp_next        = tmp_reg;
        k_next          = k_reg;
        l_next          = l_reg;
        dt_next         = dt_reg;
        a_next          = a_reg;
        ds_next         = ds_reg;
        nd_next         = nd_reg;
        best_next       = best_reg;
        best_r_next     = best_r_reg;
        best_c_next     = best_c_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        mul_start       = 1'b0;
        mul_mcand       = '0;
        mul_mplier      = '0;
        root_start      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (tram_we)
        begin
            tload_next = tload_reg + 1'b1;
        end
        if (iram_we)
        begin
            iload_next = iload_reg + 1'b1;
        end

        // shared multiplier operands
        unique case (state_reg)
            ncc_tms_pkg::ST_DT1:
            begin
                mul_mcand  = MUL_W'(t2_reg);
                mul_mplier = DW'(n_reg);
            end
            ncc_tms_pkg::ST_DT2:
            begin
                mul_mcand  = MUL_W'(t1_reg);
                mul_mplier = DW'(t1_reg);
            end
            ncc_tms_pkg::ST_ND:
            begin
                mul_mcand  = MUL_W'(dt_reg);
                mul_mplier = DW'(n_reg);
            end
            ncc_tms_pkg::ST_A1:
            begin
                mul_mcand  = MUL_W'(sxy_reg);
                mul_mplier = DW'(n_reg);
            end
            ncc_tms_pkg::ST_A2:
            begin
                mul_mcand  = MUL_W'(s1_reg);
                mul_mplier = DW'(t1_reg);
            end
            ncc_tms_pkg::ST_DS1:
            begin
                mul_mcand  = MUL_W'(s2_reg);
                mul_mplier = DW'(n_reg);
            end
            ncc_tms_pkg::ST_DS2:
            begin
                mul_mcand  = MUL_W'(s1_reg);
                mul_mplier = DW'(s1_reg);
            end
            ncc_tms_pkg::ST_K:
            begin
                mul_mcand  = MUL_W'(nd_reg);
                mul_mplier = ds_reg;
            end
            ncc_tms_pkg::ST_AA:
            begin
                mul_mcand  = MUL_W'(a_reg);
                mul_mplier = a_reg;
            end
            ncc_tms_pkg::ST_L:
            begin
                mul_mcand  = tmp_reg;
                mul_mplier = DW'(n_reg - 1'b1);
            end
            default:
            begin
            end
        endcase

        unique case (state_reg)
            ncc_tms_pkg::ST_DT1, ncc_tms_pkg::ST_DT2, ncc_tms_pkg::ST_ND,
            ncc_tms_pkg::ST_A1, ncc_tms_pkg::ST_A2, ncc_tms_pkg::ST_DS1,
            ncc_tms_pkg::ST_DS2, ncc_tms_pkg::ST_K, ncc_tms_pkg::ST_AA,
            ncc_tms_pkg::ST_L:
            begin
                mul_start   = !issued_reg;
                issued_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        unique case (state_reg)
            ncc_tms_pkg::ST_IDLE:
            begin
                if (in_acc && (in_data.func == ncc_tms_pkg::FUNC_IMAGE) && in_data.last)
                begin
                    tload_next = '0;
                    iload_next = '0;
                    state_next = ncc_tms_pkg::ST_SETUP;
                end
            end
            ncc_tms_pkg::ST_SETUP:
            begin
                tw_next         = tw_c;
                th_next         = th_c;
                iw_next         = iw_c;
                ih_next         = ih_c;
                n_next          = n_c;
                r_last_next     = IH_W'(ih_c - th_c);
                c_last_next     = IW_W'(iw_c - tw_c);
                r_next          = '0;
                c_next          = '0;
                j_next          = '0;
                row_base_next   = '0;
                tbase_next      = '0;
                issue_done_next = 1'b0;
                t1_next         = '0;
                t2_next         = '0;
                best_next       = '0;
                best_r_next     = '0;
                best_c_next     = '0;
                issued_next     = 1'b0;
                if ((tw_c > iw_c) || (th_c > ih_c))
                    state_next = ncc_tms_pkg::ST_DONE;
                else
                    state_next = ncc_tms_pkg::ST_TPASS;
            end
            ncc_tms_pkg::ST_TPASS:
            begin
                if (!issue_done_reg)
                begin
                    rd_valid_next = 1'b1;
                    if (NW'(tbase_reg) == n_reg - 1'b1)
                        issue_done_next = 1'b1;
                    else
                        tbase_next = tbase_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    t1_next = t1_reg + SW'(tram_rdata);
                    t2_next = t2_reg + QW'(16'(tram_rdata) * 16'(tram_rdata));
                end
                if (issue_done_reg && !rd_valid_reg)
                    state_next = ncc_tms_pkg::ST_DT1;
            end
            ncc_tms_pkg::ST_DT1:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    tmp_next    = mul_product;
                    state_next  = ncc_tms_pkg::ST_DT2;
                end
            end
            ncc_tms_pkg::ST_DT2:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    dt_next     = DW'(tmp_reg - mul_product);
                    // flat template: no window can score
                    if (tmp_reg == mul_product)
                        state_next = ncc_tms_pkg::ST_DONE;
                    else
                        state_next = ncc_tms_pkg::ST_ND;
                end
            end
            ncc_tms_pkg::ST_ND:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    nd_next     = (DW + NW)'(mul_product);
                    state_next  = ncc_tms_pkg::ST_WIN_INIT;
                end
            end
            ncc_tms_pkg::ST_WIN_INIT:
            begin
                line_base_next  = row_base_reg + IA_W'(c_reg);
                tbase_next      = '0;
                i_next          = '0;
                j_next          = '0;
                issue_done_next = 1'b0;
                s1_next         = '0;
                s2_next         = '0;
                sxy_next        = '0;
                state_next      = ncc_tms_pkg::ST_WIN;
            end
            ncc_tms_pkg::ST_WIN:
            begin
                if (!issue_done_reg)
                begin
                    rd_valid_next = 1'b1;
                    if (j_reg == tw_reg - 1'b1)
                    begin
                        j_next = '0;
                        if (i_reg == th_reg - 1'b1)
                        begin
                            issue_done_next = 1'b1;
                        end
                        else
                        begin
                            i_next         = i_reg + 1'b1;
                            line_base_next = line_base_reg + IA_W'(iw_reg);
                            tbase_next     = tbase_reg + TA_W'(tw_reg);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                if (rd_valid_reg)
                begin
                    s1_next  = s1_reg + SW'(iram_rdata);
                    s2_next  = s2_reg + QW'(16'(iram_rdata) * 16'(iram_rdata));
                    sxy_next = sxy_reg + QW'(16'(iram_rdata) * 16'(tram_rdata));
                end
                if (issue_done_reg && !rd_valid_reg)
                    state_next = ncc_tms_pkg::ST_A1;
            end
            ncc_tms_pkg::ST_A1:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    tmp_next    = mul_product;
                    state_next  = ncc_tms_pkg::ST_A2;
                end
            end
            ncc_tms_pkg::ST_A2:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    a_next      = DW'(tmp_reg - mul_product);
                    // only positive correlation can win
                    if (tmp_reg <= mul_product)
                        state_next = ncc_tms_pkg::ST_NEXT;
                    else
                        state_next = ncc_tms_pkg::ST_DS1;
                end
            end
            ncc_tms_pkg::ST_DS1:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    tmp_next    = mul_product;
                    state_next  = ncc_tms_pkg::ST_DS2;
                end
            end
            ncc_tms_pkg::ST_DS2:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    ds_next     = DW'(tmp_reg - mul_product);
                    if (tmp_reg == mul_product)
                        state_next = ncc_tms_pkg::ST_NEXT;
                    else
                        state_next = ncc_tms_pkg::ST_K;
                end
            end
            ncc_tms_pkg::ST_K:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    k_next      = mul_product;
                    state_next  = ncc_tms_pkg::ST_AA;
                end
            end
            ncc_tms_pkg::ST_AA:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    tmp_next    = mul_product;
                    state_next  = ncc_tms_pkg::ST_L;
                end
            end
            ncc_tms_pkg::ST_L:
            begin
                if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    l_next      = mul_product;
                    state_next  = ncc_tms_pkg::ST_ROOT;
                end
            end
            ncc_tms_pkg::ST_ROOT:
            begin
                root_start  = !issued_reg;
                issued_next = 1'b1;
                if (root_stat.done)
                begin
                    issued_next = 1'b0;
                    // ties keep the earlier window
                    if (root_q > best_reg)
                    begin
                        best_next   = root_q;
                        best_r_next = r_reg;
                        best_c_next = c_reg;
                    end
                    state_next = ncc_tms_pkg::ST_NEXT;
                end
            end
            ncc_tms_pkg::ST_NEXT:
            begin
                state_next = ncc_tms_pkg::ST_WIN_INIT;
                if (c_reg == c_last_reg)
                begin
                    c_next = '0;
                    if (r_reg == r_last_reg)
                    begin
                        state_next = ncc_tms_pkg::ST_DONE;
                    end
                    else
                    begin
                        r_next        = r_reg + 1'b1;
                        row_base_next = row_base_reg + IA_W'(iw_reg);
                    end
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            ncc_tms_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.best_score = $signed(ncc_tms_pkg::SCORE_W'(best_reg));
                    out_next.best_row   = ncc_tms_pkg::POS_W'(best_r_reg);
                    out_next.best_col   = ncc_tms_pkg::POS_W'(best_c_reg);
                    out_next.found      = (score_cmp > thr_cmp);
                    out_valid_next      = 1'b1;
                    state_next          = ncc_tms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ncc_tms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ncc_tms_pkg::ST_IDLE;
            tload_reg      <= '0;
            iload_reg      <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            issued_reg     <= 1'b0;
            best_reg       <= '0;
            best_r_reg     <= '0;
            best_c_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tload_reg      <= tload_next;
            iload_reg      <= iload_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            issued_reg     <= issued_next;
            best_reg       <= best_next;
            best_r_reg     <= best_r_next;
            best_c_reg     <= best_c_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tw_reg        <= tw_next;
        th_reg        <= th_next;
        iw_reg        <= iw_next;
        ih_reg        <= ih_next;
        n_reg         <= n_next;
        r_last_reg    <= r_last_next;
        c_last_reg    <= c_last_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        row_base_reg  <= row_base_next;
        line_base_reg <= line_base_next;
        tbase_reg     <= tbase_next;
        t1_reg        <= t1_next;
        t2_reg        <= t2_next;
        s1_reg        <= s1_next;
        s2_reg        <= s2_next;
        sxy_reg       <= sxy_next;
        tmp_reg       <= tmp_next;
        k_reg         <= k_next;
        l_reg         <= l_next;
        dt_reg        <= dt_next;
        a_reg         <= a_next;
        ds_reg        <= ds_next;
        nd_reg        <= nd_next;
        out_reg       <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `NCC_ASSERT_NEXT(a_last_starts_search, in_valid && in_ready && in_data.func && in_data.last, state_reg == ncc_tms_pkg::ST_SETUP)
    `NCC_ASSERT_SAME(a_read_in_pass, rd_valid_reg, (state_reg == ncc_tms_pkg::ST_TPASS) || (state_reg == ncc_tms_pkg::ST_WIN))
    `NCC_ASSERT_SAME(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == ncc_tms_pkg::ST_DONE)
    `NCC_ASSERT_SAME(a_mul_done_issued, mul_stat.done, issued_reg)
    `NCC_ASSERT_SAME(a_root_done_state, root_stat.done, state_reg == ncc_tms_pkg::ST_ROOT)

endmodule

>>> dv/ncc_template_match_search_test.sv
// self-checking testbench for the template match search block
module ncc_template_match_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int TPL_DEPTH = 1024;
    localparam int IMG_DEPTH = 65536;
    localparam int TARGET_REQUESTS = 1950;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_FLAT,
        FILL_EXTREME,
        FILL_NARROW
    } fill_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ncc_tms_pkg::PADDR_W-1:0] paddr = '0;
    logic [ncc_tms_pkg::PDATA_W-1:0] pwdata = '0;
    logic [ncc_tms_pkg::PDATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    ncc_tms_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b1;
    ncc_tms_pkg::out_t out_data;

    ncc_template_match_search u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [ncc_tms_pkg::CFG_TW_W-1:0] cfg_tw = ncc_tms_pkg::TW_RESET;
    logic [ncc_tms_pkg::CFG_TH_W-1:0] cfg_th = ncc_tms_pkg::TH_RESET;
    logic [ncc_tms_pkg::CFG_IW_W-1:0] cfg_iw = ncc_tms_pkg::IW_RESET;
    logic [ncc_tms_pkg::CFG_IH_W-1:0] cfg_ih = ncc_tms_pkg::IH_RESET;
    logic [ncc_tms_pkg::CFG_THR_W-1:0] cfg_thr = ncc_tms_pkg::THR_RESET;
    logic [7:0] tpl_mem [TPL_DEPTH];
    logic [7:0] img_mem [IMG_DEPTH];
    int unsigned tpl_count = 0;
    int unsigned img_count = 0;

    ncc_tms_pkg::out_t expected_matches [$];
    ncc_tms_pkg::in_t pending_requests [$];
    int unsigned requests_queued = 0;
    int unsigned results_seen = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    bit mismatch_seen = 1'b0;
    ncc_tms_pkg::out_t want;

    // generator-side view of what the stores hold
    logic [7:0] gen_tpl [TPL_DEPTH];
    int unsigned tpl_written = 0;
    int unsigned img_written = 0;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic ncc_tms_pkg::out_t predict_best_match();
        int unsigned tw, th, iw, ih, r, c, i, j, best_r, best_c;
        longint unsigned n, t1, t2, dt, s1, s2, sxy, a, ds, lo, hi, mid, x, y, best;
        logic [191:0] k0, k, lhs, rhs;
        ncc_tms_pkg::out_t res;
        tw = clamp_size(cfg_tw, 32);
        th = clamp_size(cfg_th, 32);
        iw = clamp_size(cfg_iw, 256);
        ih = clamp_size(cfg_ih, 256);
        n = tw * th;
        best = 0;
        best_r = 0;
        best_c = 0;
        if (tw <= iw && th <= ih)
        begin
            t1 = 0;
            t2 = 0;
            for (i = 0; i < n; i++)
            begin
                y = tpl_mem[i];
                t1 += y;
                t2 += y * y;
            end
            dt = n * t2 - t1 * t1;
            if (dt != 0)
            begin
                k0 = 192'(n) * 192'(dt);
                for (r = 0; r + th <= ih; r++)
                begin
                    for (c = 0; c + tw <= iw; c++)
                    begin
                        s1 = 0;
                        s2 = 0;
                        sxy = 0;
                        for (i = 0; i < th; i++)
                        begin
                            for (j = 0; j < tw; j++)
                            begin
                                x = img_mem[(r + i) * iw + c + j];
                                y = tpl_mem[i * tw + j];
                                s1 += x;
                                s2 += x * x;
                                sxy += x * y;
                            end
                        end
                        if (n * sxy > s1 * t1)
                        begin
                            a = n * sxy - s1 * t1;
                            ds = n * s2 - s1 * s1;
                            if (ds != 0)
                            begin
                                k = k0 * 192'(ds);
                                lhs = (192'(a) * 192'(a) * 192'(n - 1)) << (2 * FRAC);
                                lo = 0;
                                hi = 64'd1 << FRAC;
                                // largest q with q*q*n*ds*dt <= a*a*(n-1)*2^(2*frac)
                                while (lo < hi)
                                begin
                                    mid = lo + (hi - lo + 1) / 2;
                                    rhs = k * 192'(mid * mid);
                                    if (rhs <= lhs)
                                        lo = mid;
                                    else
                                        hi = mid - 1;
                                end
                                if (lo > best)
                                begin
                                    best = lo;
                                    best_r = r;
                                    best_c = c;
                                end
                            end
                        end
                    end
                end
            end
        end
        res.best_score = best[ncc_tms_pkg::SCORE_W-1:0];
        res.best_row = best_r[7:0];
        res.best_col = best_c[7:0];
        res.found = (best > 64'(cfg_thr));
        return res;
    endfunction

    function automatic void absorb_request(ncc_tms_pkg::in_t req);
        if (req.func == ncc_tms_pkg::FUNC_TEMPLATE)
        begin
            if (tpl_count < TPL_DEPTH)
            begin
                tpl_mem[tpl_count] = req.pixel;
                tpl_count++;
            end
        end
        else
        begin
            if (img_count < IMG_DEPTH)
            begin
                img_mem[img_count] = req.pixel;
                img_count++;
            end
            if (req.last)
            begin
                expected_matches.push_back(predict_best_match());
                tpl_count = 0;
                img_count = 0;
            end
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_request(in_data);
            if (in_valid && !in_ready)
                ;
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_requests.size() > 0)
            begin
                in_data <= pending_requests.pop_front();
                in_valid <= 1'b1;
                gap_left <= quiet ? 0 : $urandom_range(0, 4);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_matches.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    mismatch_seen <= 1'b1;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (out_data.best_score !== want.best_score)
                    begin
                        $display("%0t: best_score expected %0d actual %0d", $time,
                                 want.best_score, out_data.best_score);
                        mismatch_seen <= 1'b1;
                    end
                    if (out_data.best_row !== want.best_row)
                    begin
                        $display("%0t: best_row expected %0d actual %0d", $time,
                                 want.best_row, out_data.best_row);
                        mismatch_seen <= 1'b1;
                    end
                    if (out_data.best_col !== want.best_col)
                    begin
                        $display("%0t: best_col expected %0d actual %0d", $time,
                                 want.best_col, out_data.best_col);
                        mismatch_seen <= 1'b1;
                    end
                    if (out_data.found !== want.found)
                    begin
                        $display("%0t: found expected %0d actual %0d", $time,
                                 want.found, out_data.found);
                        mismatch_seen <= 1'b1;
                    end
                end
                // long hold-off so that later frames back up behind this one
                if (results_seen == 4)
                begin
                    out_ready <= 1'b0;
                    stall_left <= 1499;
                end
                else if (!quiet && $urandom_range(0, 1))
                begin
                    out_ready <= 1'b0;
                    stall_left <= $urandom_range(0, 3);
                end
            end
            else if (stall_left > 0)
                stall_left <= stall_left - 1;
            else
                out_ready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [2:0] idx,
                             input logic [ncc_tms_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ncc_tms_pkg::REG_TEMPLATE_WIDTH:  cfg_tw = value[ncc_tms_pkg::CFG_TW_W-1:0];
            ncc_tms_pkg::REG_TEMPLATE_HEIGHT: cfg_th = value[ncc_tms_pkg::CFG_TH_W-1:0];
            ncc_tms_pkg::REG_IMAGE_WIDTH:     cfg_iw = value[ncc_tms_pkg::CFG_IW_W-1:0];
            ncc_tms_pkg::REG_IMAGE_HEIGHT:    cfg_ih = value[ncc_tms_pkg::CFG_IH_W-1:0];
            ncc_tms_pkg::REG_MATCH_THRESHOLD: cfg_thr = value[ncc_tms_pkg::CFG_THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned tw, th, iw, ih, thr);
        apb_write(ncc_tms_pkg::REG_TEMPLATE_WIDTH, tw);
        apb_write(ncc_tms_pkg::REG_TEMPLATE_HEIGHT, th);
        apb_write(ncc_tms_pkg::REG_IMAGE_WIDTH, iw);
        apb_write(ncc_tms_pkg::REG_IMAGE_HEIGHT, ih);
        apb_write(ncc_tms_pkg::REG_MATCH_THRESHOLD, thr);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_matches.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic void push_request(input logic func, input logic [7:0] pixel,
                                         input logic last);
        ncc_tms_pkg::in_t req;
        req.func = func;
        req.pixel = pixel;
        req.last = last;
        pending_requests.push_back(req);
        requests_queued++;
    endfunction

    function automatic logic [7:0] pick_pixel(fill_t fill, logic [7:0] base);
        case (fill)
            FILL_FLAT:    return base;
            FILL_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            FILL_NARROW:  return (base > 8'd251) ? base - 8'($urandom_range(0, 3))
                                                 : base + 8'($urandom_range(0, 3));
            default:      return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic fill_t pick_fill();
        case ($urandom_range(0, 9))
            0:       return FILL_FLAT;
            1:       return FILL_EXTREME;
            2:       return FILL_NARROW;
            default: return FILL_RANDOM;
        endcase
    endfunction

    // one frame at the current configuration; keeps every read window on written pixels
    task automatic queue_frame();
        int unsigned tw, th, iw, ih, n, img_n, cnt, i, r0, c0, copies;
        logic [7:0] p;
        fill_t fill;
        logic [7:0] base;
        logic [7:0] img_px [];
        tw = clamp_size(cfg_tw, 32);
        th = clamp_size(cfg_th, 32);
        iw = clamp_size(cfg_iw, 256);
        ih = clamp_size(cfg_ih, 256);
        n = tw * th;
        if (tpl_written < n || $urandom_range(0, 2) != 0)
        begin
            fill = pick_fill();
            base = 8'($urandom_range(0, 255));
            cnt = n + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
            for (i = 0; i < cnt; i++)
            begin
                p = pick_pixel(fill, base);
                if (i < TPL_DEPTH)
                    gen_tpl[i] = p;
                push_request(ncc_tms_pkg::FUNC_TEMPLATE, p, 1'($urandom_range(0, 1)));
            end
            if (cnt > tpl_written)
                tpl_written = (cnt > TPL_DEPTH) ? TPL_DEPTH : cnt;
        end
        img_n = iw * ih;
        cnt = img_n;
        if (img_written >= img_n && $urandom_range(0, 7) == 0)
            cnt = $urandom_range(1, img_n);
        else if ($urandom_range(0, 7) == 0)
            cnt = img_n + $urandom_range(1, 3);
        img_px = new[cnt];
        fill = pick_fill();
        base = 8'($urandom_range(0, 255));
        for (i = 0; i < cnt; i++)
            img_px[i] = pick_pixel(fill, base);
        // plant copies of the template, sometimes twice to make ties
        if (tw <= iw && th <= ih && cnt >= img_n && $urandom_range(0, 2) != 0)
        begin
            copies = $urandom_range(1, 2);
            repeat (copies)
            begin
                r0 = $urandom_range(0, ih - th);
                c0 = $urandom_range(0, iw - tw);
                for (i = 0; i < n; i++)
                    img_px[(r0 + i / tw) * iw + c0 + i % tw] = gen_tpl[i];
            end
        end
        for (i = 0; i < cnt; i++)
            push_request(ncc_tms_pkg::FUNC_IMAGE, img_px[i], i == cnt - 1);
        if (cnt > img_written)
            img_written = cnt;
    endtask

    initial
    begin
        int unsigned tw, th, iw, ih, thr, frames, group;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // basic positive match
        set_config(2, 1, 3, 1, 0);
        push_request(ncc_tms_pkg::FUNC_TEMPLATE, 8'd0, 1'b1);
        push_request(ncc_tms_pkg::FUNC_TEMPLATE, 8'd255, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd0, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd255, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd0, 1'b1);
        wait_idle();
        // flat template
        set_config(2, 1, 3, 1, 2097151);
        push_request(ncc_tms_pkg::FUNC_TEMPLATE, 8'd7, 1'b0);
        push_request(ncc_tms_pkg::FUNC_TEMPLATE, 8'd7, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd255, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd0, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd9, 1'b1);
        wait_idle();
        // one pixel template
        set_config(1, 1, 2, 1, 1048576);
        push_request(ncc_tms_pkg::FUNC_TEMPLATE, 8'd5, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd1, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd2, 1'b1);
        wait_idle();
        // template wider than image
        set_config(3, 1, 2, 1, 655360);
        push_request(ncc_tms_pkg::FUNC_TEMPLATE, 8'd1, 1'b0);
        push_request(ncc_tms_pkg::FUNC_TEMPLATE, 8'd2, 1'b0);
        push_request(ncc_tms_pkg::FUNC_TEMPLATE, 8'd3, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd128, 1'b0);
        push_request(ncc_tms_pkg::FUNC_IMAGE, 8'd127, 1'b1);
        wait_idle();
        tpl_written = 3;
        img_written = 3;
        for (int i = 0; i < 3; i++)
            gen_tpl[i] = 8'(i + 1);

        group = 0;
        while (requests_queued < TARGET_REQUESTS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       thr = 0;
                1:       thr = ($urandom_range(0, 1)) ? 1048576 : 2097151;
                default: thr = $urandom_range(0, 65536);
            endcase
            if (group == 3)
            begin
                // overfill the template store with oversized, clamped sizes
                set_config(63, 63, 0, 0, thr);
                for (int i = 0; i < TPL_DEPTH + 6; i++)
                begin
                    if (i < TPL_DEPTH)
                        gen_tpl[i] = 8'($urandom_range(0, 255));
                    push_request(ncc_tms_pkg::FUNC_TEMPLATE, gen_tpl[i % TPL_DEPTH], 1'b0);
                end
                push_request(ncc_tms_pkg::FUNC_IMAGE, 8'($urandom_range(0, 255)), 1'b1);
                tpl_written = TPL_DEPTH;
                if (img_written < 1)
                    img_written = 1;
                frames = 0;
            end
            else
            begin
                case ($urandom_range(0, 31))
                    0:
                    begin
                        tw = $urandom_range(0, 1) ? 32 : $urandom_range(33, 63);
                        th = $urandom_range(1, 2);
                        iw = 32 + $urandom_range(0, 6);
                        ih = th + $urandom_range(0, 1);
                    end
                    1:
                    begin
                        th = $urandom_range(0, 1) ? 32 : $urandom_range(33, 63);
                        tw = $urandom_range(1, 2);
                        iw = tw + $urandom_range(0, 1);
                        ih = 32 + $urandom_range(0, 4);
                    end
                    2:
                    begin
                        iw = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                        ih = 1;
                        tw = $urandom_range(2, 3);
                        th = 1;
                    end
                    3:
                    begin
                        ih = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                        iw = 1;
                        th = 2;
                        tw = 1;
                    end
                    4:
                    begin
                        tw = $urandom_range(2, 5);
                        th = $urandom_range(1, 3);
                        iw = $urandom_range(1, tw - 1);
                        ih = $urandom_range(1, 4);
                    end
                    5:
                    begin
                        tw = $urandom_range(0, 2);
                        th = (tw == 0) ? 2 : 0;
                        iw = $urandom_range(0, 5);
                        ih = $urandom_range(0, 4);
                    end
                    default:
                    begin
                        tw = $urandom_range(1, 4);
                        th = (tw == 1) ? $urandom_range(2, 3) : $urandom_range(1, 3);
                        iw = tw + $urandom_range(0, 5);
                        ih = th + $urandom_range(0, 4);
                    end
                endcase
                set_config(tw, th, iw, ih, thr);
                frames = (group == 0) ? 4 : $urandom_range(1, 4);
            end
            for (int f = 0; f < frames; f++)
                queue_frame();
            wait_idle();
            group++;
        end

        repeat (50) @(posedge clk);
        if (!mismatch_seen && expected_matches.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
